// ===== design/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared constants and types of the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam int FRAME_BYTES    = 25;
    localparam int FILL_W         = $clog2(FRAME_BYTES + 1);
    localparam int CHANNELS       = 16;
    localparam int CH_IDX_W       = $clog2(CHANNELS);
    localparam int CH_BITS        = 11;
    localparam int CHAN_BYTES     = 22;
    localparam int CHAN_DATA_BITS = CHAN_BYTES * 8;
    localparam int CH_POS_W       = $clog2(CHAN_DATA_BITS);
    localparam int FLAG_POS       = 23;
    localparam int LOST_BIT       = 2;
    localparam int FS_BIT         = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int TICK_W         = 32;
    localparam int TIMEOUT_W      = 16;
    localparam int OUT_DATA_W     = 24;

    localparam logic [7:0]           HDR_BYTE      = 8'h0F;
    localparam logic [7:0]           FTR_BYTE      = 8'h00;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_TICK     = 1'b1;
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic                      link_valid;
        logic                      lost_flag;
        logic                      failsafe;
        logic [CHAN_DATA_BITS-1:0] chan_bits;
    } t_desc;

endpackage

// ===== design/sbd_front.sv =====
// ----------------------------------------------------------------------------
// sbd_front
// Accepts bytes and ticks, slides the byte window, detects frames, tracks
// link age and pushes one descriptor per frame or tick into the queue.
// ----------------------------------------------------------------------------
module sbd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [sbd_pkg::TIMEOUT_W-1:0]   i_cfg_wdata,
    input  logic                            i_queue_full,
    output logic                            o_push,
    output sbd_pkg::t_desc                  o_desc
);
    import sbd_pkg::*;

    logic [7:0]           r_win [FRAME_BYTES];
    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill;
    logic [TICK_W-1:0]    r_tick;
    logic [TICK_W-1:0]    n_tick;
    logic [TICK_W-1:0]    r_last_clean;
    logic                 r_clean_seen;
    logic                 r_fs;
    logic                 r_lost;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [TICK_W-1:0]    w_age;
    logic                 w_accept;
    logic                 w_is_tick;
    logic                 w_match;
    logic [7:0]           w_flags;
    logic                 w_link_valid;

    assign s_axis_tready = !i_queue_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_tick     = (s_axis_tuser == CMD_TICK);

    assign w_match = (r_fill >= FILL_W'(FRAME_BYTES - 1))
                  && (r_win[1] == HDR_BYTE)
                  && (s_axis_tdata == FTR_BYTE);
    assign w_flags = r_win[FLAG_POS + 1];

    assign n_tick       = r_tick + TICK_W'(1);
    assign w_age        = n_tick - r_last_clean;
    assign w_link_valid = r_clean_seen && !r_fs && (w_age < TICK_W'(r_timeout));

    always_comb begin
        if (w_match) begin
            n_fill = '0;
        end else if (r_fill == FILL_W'(FRAME_BYTES)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_comb begin
        o_push            = w_accept && (w_is_tick || w_match);
        o_desc.kind       = w_is_tick ? KIND_STATUS : KIND_CHANNEL;
        o_desc.link_valid = w_is_tick && w_link_valid;
        o_desc.lost_flag  = w_is_tick ? r_lost : w_flags[LOST_BIT];
        o_desc.failsafe   = w_is_tick ? r_fs   : w_flags[FS_BIT];
        for (int k = 0; k < CHAN_BYTES; k++) begin
            o_desc.chan_bits[8*k +: 8] = r_win[k + 2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_tick) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[FRAME_BYTES - 1] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_tick       <= '0;
            r_last_clean <= '0;
            r_clean_seen <= 1'b0;
            r_fs         <= 1'b0;
            r_lost       <= 1'b0;
            r_timeout    <= TIMEOUT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (w_accept && w_is_tick) begin
                r_tick <= n_tick;
            end
            if (w_accept && !w_is_tick) begin
                r_fill <= n_fill;
                if (w_match) begin
                    r_lost <= w_flags[LOST_BIT];
                    r_fs   <= w_flags[FS_BIT];
                    if (!w_flags[LOST_BIT] && !w_flags[FS_BIT]) begin
                        r_last_clean <= r_tick;
                        r_clean_seen <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ===== design/sbd_queue.sv =====
// ----------------------------------------------------------------------------
// sbd_queue
// Small descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
module sbd_queue #(
    parameter int DEPTH = sbd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sbd_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output sbd_pkg::t_desc o_head
);
    import sbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== design/sbd_back.sv =====
// ----------------------------------------------------------------------------
// sbd_back
// Drains descriptors: one status transaction per tick, sixteen unpacked
// channel transactions per frame, through a registered output stage.
// ----------------------------------------------------------------------------
module sbd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_head_valid,
    input  sbd_pkg::t_desc                   i_head,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sbd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);
    import sbd_pkg::*;

    logic [CH_IDX_W-1:0]   r_ch;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_kind;
    logic                  r_out_last;
    logic                  w_out_free;
    logic                  w_load;
    logic                  w_is_status;
    logic                  w_last_ch;
    logic [CH_POS_W-1:0]   w_pos;
    logic [CH_BITS-1:0]    w_value;
    logic [OUT_DATA_W-1:0] w_data;

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_load      = w_out_free && i_head_valid;
    assign w_is_status = (i_head.kind == KIND_STATUS);
    assign w_last_ch   = (r_ch == CH_IDX_W'(CHANNELS - 1));
    assign o_pop       = w_load && (w_is_status || w_last_ch);

    assign w_pos   = CH_POS_W'(r_ch) * CH_POS_W'(CH_BITS);
    assign w_value = i_head.chan_bits[w_pos +: CH_BITS];

    always_comb begin
        w_data         = '0;
        w_data[3:0]    = w_is_status ? '0 : r_ch;
        w_data[14:4]   = w_is_status ? '0 : w_value;
        w_data[15]     = i_head.lost_flag;
        w_data[16]     = i_head.failsafe;
        w_data[17]     = i_head.link_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_data;
            r_out_kind <= i_head.kind;
            r_out_last <= w_is_status || w_last_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load && !w_is_status) begin
                r_ch <= w_last_ch ? '0 : r_ch + CH_IDX_W'(1);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_frame_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ch != '0) |-> (i_head_valid && (i_head.kind == KIND_CHANNEL)))
        else $error("frame descriptor left queue mid-frame");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_STATUS)) |->
        (r_out_last && (r_out_data[14:0] == '0)))
        else $error("status transaction malformed");
    a_channel_no_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_CHANNEL)) |-> !r_out_data[17])
        else $error("link flag set on channel transaction");
`endif

endmodule

// ===== design/sbus_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_decoder_top
// SBUS frame decoder: byte window, frame detect, channel unpack, link status.
//
//   Channel   Dir  Signals                Content (low bit first)
//   s_axis    in   tvalid tready tdata    tdata[7:0] data_byte
//                  tuser                  tuser[0] command (0 byte, 1 tick)
//   m_axis    out  tvalid tready tdata    tdata[3:0] channel_index,
//                  tuser tlast            [14:4] channel_value, [15] lost flag,
//                                         [16] failsafe, [17] link_valid,
//                                         [23:18] zero; tuser kind; tlast last
//   cfg       in   i_cfg_we i_cfg_wdata   link timeout in ticks, 16 bits
//
// Input transactions are taken one per cycle while the descriptor queue has
// room. A tick yields one status transaction, queued then registered. A frame
// yields sixteen channel transactions, one per cycle unless m_axis stalls, set
// by the back part walking the channel counter. Synchronous active-low reset; no
// clearing pass. Output stalls back up through the queue to s_axis tready.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_top #(
    parameter int QUEUE_DEPTH = sbd_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] data_byte
    input  logic                             s_axis_tuser,   // [0] command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sbd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // index, value, lost, fs, valid
    output logic                             m_axis_tuser,   // [0] kind
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [sbd_pkg::TIMEOUT_W-1:0]    i_cfg_wdata
);
    import sbd_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_head_valid;
    t_desc w_desc;
    t_desc w_head;

    sbd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_desc        (w_desc)
    );

    sbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_desc       (w_desc),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    sbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
